/* rtl/trpfl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trpfl_pkg: shared types and constants of the page free list allocator
// Field widths, config register indexes, operation and status codes, and the
// command/status bundles between controller, datapath and stack units.
// ----------------------------------------------------------------------------
package trpfl_pkg;

    // field widths
    localparam int ADDR_W      = 64;
    localparam int START_W     = 52;
    localparam int KCNT_W      = 14;
    localparam int END_W       = 53;
    localparam int FC_W        = 14;
    localparam int MODE_W      = 2;
    localparam int STATUS_W    = 2;

    // stream word widths
    localparam int S_TDATA_W   = 64;
    localparam int S_TUSER_W   = 3;
    localparam int M_TDATA_W   = 80;
    localparam int M_TUSER_W   = 2;

    // config port
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 53;

    localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KCNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END   = 2'd2;

    localparam logic [START_W-1:0] START_RST = 52'd524288;
    localparam logic [KCNT_W-1:0]  KCNT_RST  = 14'd1024;
    localparam logic [END_W-1:0]   END_RST   = 53'd529408;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REBUILD = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic walk_step;
        logic commit;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic rebuild_req;
        logic walk_done;
        logic out_free;
    } ctrl_sts_t;

    // datapath to one stack unit
    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
        logic rd_en;
    } stack_cmd_t;

endpackage

/* rtl/trpfl_stack.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trpfl_stack: one lifo free list
// Entry memory with a top-of-stack count; pushes write at the top, a read
// of the entry just below the top returns registered data in the following cycle.
// ----------------------------------------------------------------------------
module trpfl_stack #(
    parameter int DEPTH = 8192,
    parameter int IDX_W = 13,
    parameter int CNT_W = 14
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  trpfl_pkg::stack_cmd_t cmd,
    input  logic [IDX_W-1:0]      wr_data,
    output logic [CNT_W-1:0]      top,
    output logic [IDX_W-1:0]      rd_data
);

    logic [IDX_W-1:0] mem [DEPTH];
    logic [CNT_W-1:0] top_reg;
    logic [CNT_W-1:0] top_next;
    logic [CNT_W-1:0] top_m1;
    logic [IDX_W-1:0] rd_data_reg;

    assign top_m1 = top_reg - CNT_W'(1);

    // top-of-stack count
    always_comb
    begin
        top_next = top_reg;
        if (cmd.clear)
        begin
            top_next = '0;
        end
        else if (cmd.push)
        begin
            top_next = top_reg + CNT_W'(1);
        end
        else if (cmd.pop)
        begin
            top_next = top_m1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg <= '0;
        end
        else
        begin
            top_reg <= top_next;
        end
    end

    // entry memory, write at top, registered read below top
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[top_reg[IDX_W-1:0]] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[top_m1[IDX_W-1:0]];
        end
    end

    assign top     = top_reg;
    assign rd_data = rd_data_reg;

endmodule

/* rtl/trpfl_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trpfl_datapath: config registers, free checks, stacks and output register
// Captures the input word, evaluates alloc/free/rebuild against both free
// lists and loads the result word into the output register.
// ----------------------------------------------------------------------------
module trpfl_datapath #(
    parameter int PAGE_BYTES = 4096,
    parameter int MAX_PAGES  = 8192
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  trpfl_pkg::ctrl_cmd_t                   cmd,
    output trpfl_pkg::ctrl_sts_t                   sts,
    input  logic                                   cfg_we,
    input  logic [trpfl_pkg::CFG_IDX_W-1:0]        cfg_addr,
    input  logic [trpfl_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic [trpfl_pkg::S_TDATA_W-1:0]        s_tdata,
    input  logic [trpfl_pkg::S_TUSER_W-1:0]        s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [trpfl_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic [trpfl_pkg::M_TUSER_W-1:0]        m_tuser
);

    localparam int SHIFT = $clog2(PAGE_BYTES);
    localparam int IDX_W = $clog2(MAX_PAGES);
    localparam int CNT_W = $clog2(MAX_PAGES + 1);
    localparam int CMP_W = (CNT_W > trpfl_pkg::KCNT_W) ? CNT_W : trpfl_pkg::KCNT_W;
    localparam int AW    = trpfl_pkg::ADDR_W;
    localparam int PAD_W = trpfl_pkg::M_TDATA_W - AW - trpfl_pkg::FC_W;

    localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_PAGES);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(MAX_PAGES - 1);
    localparam logic [AW-1:0]    MAX_PG64  = AW'(MAX_PAGES);

    // config registers
    logic [trpfl_pkg::START_W-1:0] start_reg;
    logic [trpfl_pkg::KCNT_W-1:0]  kcnt_reg;
    logic [trpfl_pkg::END_W-1:0]   end_reg;

    // captured item and early checks
    logic [trpfl_pkg::MODE_W-1:0]  mode_reg;
    logic                          kern_reg;
    logic                          misal_reg;
    logic                          below_reg;
    logic                          above_reg;
    logic [AW-1:0]                 diff_reg;
    logic [CNT_W-1:0]              ulim_reg;

    // rebuild walk
    logic [IDX_W-1:0]              off_reg;
    logic [IDX_W-1:0]              off_next;

    // output register
    logic                          m_tvalid_reg;
    logic                          m_tvalid_next;
    logic [AW-1:0]                 m_addr_reg;
    logic [trpfl_pkg::STATUS_W-1:0] m_st_reg;
    logic [trpfl_pkg::FC_W-1:0]    m_cnt_reg;

    // input decode
    logic [trpfl_pkg::MODE_W-1:0]  in_mode;
    logic                          in_kern;
    logic [AW-1:0]                 in_pn;
    logic [trpfl_pkg::END_W-1:0]   span;

    // stacks
    trpfl_pkg::stack_cmd_t         k_cmd;
    trpfl_pkg::stack_cmd_t         u_cmd;
    logic [IDX_W-1:0]              wr_data;
    logic [CNT_W-1:0]              k_top;
    logic [CNT_W-1:0]              u_top;
    logic [IDX_W-1:0]              k_off;
    logic [IDX_W-1:0]              u_off;

    // step evaluation
    logic [CNT_W-1:0]              sel_top;
    logic [IDX_W-1:0]              sel_off;
    logic                          bad_free;
    logic                          alloc_ok;
    logic                          free_ok;
    logic [AW-1:0]                 res_addr;
    logic [trpfl_pkg::STATUS_W-1:0] res_st;
    logic [CNT_W-1:0]              res_cnt;
    logic                          k_walk_wr;
    logic                          u_walk_wr;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= trpfl_pkg::START_RST;
            kcnt_reg  <= trpfl_pkg::KCNT_RST;
            end_reg   <= trpfl_pkg::END_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                trpfl_pkg::CFG_START: start_reg <= cfg_data[trpfl_pkg::START_W-1:0];
                trpfl_pkg::CFG_KCNT:  kcnt_reg  <= cfg_data[trpfl_pkg::KCNT_W-1:0];
                trpfl_pkg::CFG_END:   end_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // input word decode
    assign in_mode = s_tuser[trpfl_pkg::MODE_W-1:0];
    assign in_kern = s_tuser[trpfl_pkg::MODE_W];
    assign in_pn   = s_tdata >> SHIFT;
    assign span    = (end_reg > trpfl_pkg::END_W'(start_reg))
                     ? end_reg - trpfl_pkg::END_W'(start_reg) : '0;

    // item capture with range checks and rebuild user limit
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mode_reg  <= in_mode;
            kern_reg  <= in_kern;
            misal_reg <= |s_tdata[SHIFT-1:0];
            below_reg <= in_pn < AW'(start_reg);
            above_reg <= in_pn >= AW'(end_reg);
            diff_reg  <= in_pn - AW'(start_reg);
            ulim_reg  <= (span >= trpfl_pkg::END_W'(MAX_PAGES))
                         ? MAX_CNT : span[CNT_W-1:0];
        end
    end

    // walk offset counter
    always_comb
    begin
        off_next = off_reg;
        if (cmd.accept)
        begin
            off_next = '0;
        end
        else if (cmd.walk_step)
        begin
            off_next = off_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg <= '0;
        end
        else
        begin
            off_reg <= off_next;
        end
    end

    // step result for the captured item
    assign sel_top  = kern_reg ? k_top : u_top;
    assign sel_off  = kern_reg ? k_off : u_off;
    assign bad_free = misal_reg | below_reg | above_reg | (diff_reg >= MAX_PG64);

    always_comb
    begin
        res_addr = '0;
        res_st   = trpfl_pkg::ST_OK;
        res_cnt  = sel_top;
        alloc_ok = 1'b0;
        free_ok  = 1'b0;
        unique case (mode_reg)
            trpfl_pkg::MODE_ALLOC:
            begin
                if (sel_top == '0)
                begin
                    res_st  = trpfl_pkg::ST_EMPTY;
                end
                else
                begin
                    alloc_ok = 1'b1;
                    res_addr = (AW'(start_reg) + AW'(sel_off)) << SHIFT;
                    res_cnt  = sel_top - CNT_W'(1);
                end
            end
            trpfl_pkg::MODE_FREE:
            begin
                if (bad_free)
                begin
                    res_st = trpfl_pkg::ST_BAD;
                end
                else if (sel_top == MAX_CNT)
                begin
                    res_st = trpfl_pkg::ST_FULL;
                end
                else
                begin
                    free_ok = 1'b1;
                    res_cnt = sel_top + CNT_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // rebuild loads kernel pages first, user pages above them
    assign k_walk_wr = CMP_W'(off_reg) < CMP_W'(kcnt_reg);
    assign u_walk_wr = !k_walk_wr && (CNT_W'(off_reg) < ulim_reg);
    assign wr_data   = cmd.walk_step ? off_reg : diff_reg[IDX_W-1:0];

    always_comb
    begin
        k_cmd.clear = cmd.accept & (in_mode == trpfl_pkg::MODE_REBUILD);
        k_cmd.rd_en = cmd.accept;
        k_cmd.push  = (cmd.walk_step & k_walk_wr) | (cmd.commit & free_ok & kern_reg);
        k_cmd.pop   = cmd.commit & alloc_ok & kern_reg;
        u_cmd.clear = k_cmd.clear;
        u_cmd.rd_en = cmd.accept;
        u_cmd.push  = (cmd.walk_step & u_walk_wr) | (cmd.commit & free_ok & !kern_reg);
        u_cmd.pop   = cmd.commit & alloc_ok & !kern_reg;
    end

    trpfl_stack #(
        .DEPTH   (MAX_PAGES),
        .IDX_W   (IDX_W),
        .CNT_W   (CNT_W)
    ) u_kstack (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (k_cmd),
        .wr_data (wr_data),
        .top     (k_top),
        .rd_data (k_off)
    );

    trpfl_stack #(
        .DEPTH   (MAX_PAGES),
        .IDX_W   (IDX_W),
        .CNT_W   (CNT_W)
    ) u_ustack (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (u_cmd),
        .wr_data (wr_data),
        .top     (u_top),
        .rd_data (u_off)
    );

    // output register
    assign m_tvalid_next = cmd.commit | (m_tvalid_reg & !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            m_addr_reg <= res_addr;
            m_st_reg   <= res_st;
            m_cnt_reg  <= trpfl_pkg::FC_W'(res_cnt);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, m_cnt_reg, m_addr_reg};
    assign m_tuser  = m_st_reg;

    // status to controller
    assign sts.rebuild_req = in_mode == trpfl_pkg::MODE_REBUILD;
    assign sts.walk_done   = off_reg == LAST_IDX;
    assign sts.out_free    = !m_tvalid_reg | m_tready;

    // checks
    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> m_tvalid)
        else $error("result not presented after commit");

    a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (k_top <= MAX_CNT) && (u_top <= MAX_CNT))
        else $error("free list count beyond capacity");

    a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == trpfl_pkg::ST_EMPTY) |->
        (m_tdata[AW-1:0] == '0) && (m_cnt_reg == '0))
        else $error("empty-list result carries data");

    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> sts.out_free)
        else $error("commit into occupied output register");

endmodule

/* rtl/trpfl_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trpfl_ctrl: sequencing state machine
// Takes one input word at a time, runs the rebuild walk when asked and
// commits the result once the output register can take it.
// ----------------------------------------------------------------------------
module trpfl_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  trpfl_pkg::ctrl_sts_t sts,
    output trpfl_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_EXEC = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state and commands
    always_comb
    begin
        state_next    = state_reg;
        s_tready      = 1'b0;
        cmd.accept    = 1'b0;
        cmd.walk_step = 1'b0;
        cmd.commit    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = sts.rebuild_req ? S_WALK : S_EXEC;
                end
            end
            S_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (sts.walk_done)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.commit = sts.out_free;
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // one word in flight
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> !s_tready)
        else $error("second word accepted before result commit");

endmodule

/* rtl/two_region_page_free_list_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_region_page_free_list_core: kernel/user lifo physical page allocator
// Command words on the s_ stream (alloc, free, rebuild), one result word per
// command on the m_ stream, region bounds on a plain config write port.
//   - s_ channel: tuser carries mode and the kernel/user select, tdata the
//     byte address of a page to free. One word is taken at a time.
//   - m_ channel: tdata carries the allocated address and the free count of
//     the selected list, tuser the status code.
//   - alloc, free and spare-mode words: stack read and range checks register
//     at accept, then the commit step loads the output register once it is
//     free, and a new word is taken only after that commit.
//   - rebuild walks every page offset, one per cycle, writing at most one
//     list entry per cycle, then commits its result the same way as the
//     other words; the next word is taken only after that commit.
//   - config writes must go in only while no command is in progress; the block
//     itself does not enforce it; reset empties both lists and restores the default region bounds.
//   - when m_tready is low the result stays in the output register; a new
//     command is taken meanwhile and waits at its commit step, s_tready low.
// ----------------------------------------------------------------------------
module two_region_page_free_list_core #(
    parameter int PAGE_BYTES = 4096,
    parameter int MAX_PAGES  = 8192
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [trpfl_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [trpfl_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [trpfl_pkg::S_TDATA_W-1:0]  s_tdata,   // [63:0] page_addr
    input  logic [trpfl_pkg::S_TUSER_W-1:0]  s_tuser,   // [1:0] mode, [2] kernel_sel
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [trpfl_pkg::M_TDATA_W-1:0]  m_tdata,   // [63:0] result_addr, [77:64] free_count
    output logic [trpfl_pkg::M_TUSER_W-1:0]  m_tuser    // [1:0] status
);

    trpfl_pkg::ctrl_cmd_t cmd;
    trpfl_pkg::ctrl_sts_t sts;

    // sequencing
    trpfl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // lists, checks and result register
    trpfl_datapath #(
        .PAGE_BYTES (PAGE_BYTES),
        .MAX_PAGES  (MAX_PAGES)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
